// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the flow learning table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge outside of reset.
`define FLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising clk edge, reset included.
`define FLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/flt_pkg.sv -----
// ----------------------------------------------------------------------------
// flt_pkg
// Types and constants of the flow learning table.
// ----------------------------------------------------------------------------
package flt_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int INST_W            = 9;
  localparam int IDX_W             = 8;

  localparam logic [INST_W-1:0] INST_ONE = INST_W'(1);

  localparam logic OP_LEARN = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_KNOWN = 2'd0,
    STATUS_ADDED = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_READ  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_READ_DATA
  } state_t;

  typedef struct packed {
    logic             opcode;
    logic [31:0]      src_ip;
    logic [7:0]       protocol;
    logic [15:0]      src_port;
    logic [IDX_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [INST_W-1:0] instance_res;
    logic              entry_valid;
    logic [31:0]       entry_address;
    logic [7:0]        entry_protocol;
    logic [15:0]       entry_port;
    logic              first_of_address;
    logic              any_learned;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       address;
    logic [7:0]        protocol;
    logic [15:0]       port;
    logic [INST_W-1:0] inst;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic rd_issue;
    logic fin_known;
    logic fin_learn;
    logic fin_read;
  } cmd_t;

  typedef struct packed {
    logic new_read;
    logic hit;
    logic scan_end;
  } sts_t;

endpackage

// ----- src/flow_learning_table_unit.sv -----
// ----------------------------------------------------------------------------
// flow_learning_table_unit
// Flow learning table: learns (address, protocol, port) triples in insertion
// order and returns stored entries by index.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the request is taken at the
//   rising edge where start is high and busy is low. busy stays high until
//   the request has finished.
//   Result channel: result is valid for exactly one cycle while done is high.
//   The receiver cannot stall; it must take the result in that cycle.
//   A learn request walks the stored entries one per cycle through the
//   single read port of the entry RAM and stops early on an exact match.
//   A read request issues the RAM read in the read state and takes the entry
//   in the read-data state. A new request may be accepted in the cycle that
//   done is high. Only one request is in flight at a time, and a learn
//   request is bounded by the scan of the stored entries.
//   Reset (rst, synchronous) empties the table by clearing the entry count
//   and the learned flag; the RAM contents are not cleared and need no
//   clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flow_learning_table_unit #(
  parameter int TABLE_ENTRIES = flt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  flt_pkg::req_t req,
  output logic          done,
  output flt_pkg::rsp_t result
);

  flt_pkg::cmd_t cmd;
  flt_pkg::sts_t sts;

  flt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  flt_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cmd   (cmd),
    .sts   (sts),
    .done  (done),
    .result(result)
  );

  `FLT_ASSERT(a_done_idle, done |-> !busy, "result strobe while still busy")

endmodule

// ----- src/flt_ram.sv -----
// ----------------------------------------------------------------------------
// flt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module flt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/flt_ctrl.sv -----
// ----------------------------------------------------------------------------
// flt_ctrl
// Sequencer of the flow learning table: accept, scan, read and finish.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  flt_pkg::sts_t sts,
  output logic          busy,
  output flt_pkg::cmd_t cmd
);

  flt_pkg::state_t state;
  flt_pkg::state_t state_next;
  logic [2:0]      fin_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      flt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sts.new_read ? flt_pkg::ST_READ : flt_pkg::ST_SCAN;
        end
      end
      flt_pkg::ST_SCAN: begin
        if (sts.hit || sts.scan_end) begin
          state_next = flt_pkg::ST_IDLE;
        end
      end
      flt_pkg::ST_READ:      state_next = flt_pkg::ST_READ_DATA;
      flt_pkg::ST_READ_DATA: state_next = flt_pkg::ST_IDLE;
      default:               state_next = flt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      flt_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      flt_pkg::ST_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.fin_known = sts.hit;
        cmd.fin_learn = !sts.hit && sts.scan_end;
      end
      flt_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
      end
      flt_pkg::ST_READ_DATA: begin
        cmd.fin_read = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign fin_set = {cmd.fin_known, cmd.fin_learn, cmd.fin_read};

  `FLT_ASSERT_ALWAYS(a_one_finish, $onehot0(fin_set), "two finishes at once")
  `FLT_ASSERT(a_load_busy, cmd.load |=> busy, "request accepted but controller idle")

endmodule

// ----- src/flt_dp.sv -----
// ----------------------------------------------------------------------------
// flt_dp
// Datapath of the flow learning table: entry RAM, scan pointer, counters
// and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flt_dp #(
  parameter int TABLE_ENTRIES = flt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  flt_pkg::req_t req,
  input  flt_pkg::cmd_t cmd,
  output flt_pkg::sts_t sts,
  output logic          done,
  output flt_pkg::rsp_t result
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int WW = (CW > flt_pkg::IDX_W) ? CW : flt_pkg::IDX_W;
  localparam int EW = $bits(flt_pkg::entry_t);

  flt_pkg::req_t             req_q;
  logic [CW-1:0]             ptr;
  logic                      cmp_v;
  logic [flt_pkg::INST_W-1:0] same;
  logic [CW-1:0]             count;
  logic                      learned;

  logic                      rd_en;
  logic                      full;
  logic                      addr_eq;
  logic                      idx_ok;
  logic                      fin;
  logic [flt_pkg::INST_W-1:0] inst_new;
  logic                      we;
  logic [AW-1:0]             raddr;
  logic [EW-1:0]             rdata;
  flt_pkg::entry_t           rd_entry;
  flt_pkg::entry_t           wr_entry;
  flt_pkg::rsp_t             rsp_next;

  flt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count[AW-1:0]),
    .wdata(wr_entry),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_entry = flt_pkg::entry_t'(rdata);
  assign rd_en    = cmd.scan && (ptr < count);
  assign raddr    = cmd.rd_issue ? AW'(req_q.entry_index) : ptr[AW-1:0];
  assign full     = (count == CW'(TABLE_ENTRIES));
  assign addr_eq  = cmp_v && (rd_entry.address == req_q.src_ip);
  assign idx_ok   = (WW'(req_q.entry_index) < WW'(count));
  assign inst_new = same + flt_pkg::INST_ONE;
  assign fin      = cmd.fin_known || cmd.fin_learn || cmd.fin_read;
  assign we       = cmd.fin_learn && !full;

  assign wr_entry.address  = req_q.src_ip;
  assign wr_entry.protocol = req_q.protocol;
  assign wr_entry.port     = req_q.src_port;
  assign wr_entry.inst     = inst_new;

  assign sts.new_read = (req.opcode == flt_pkg::OP_READ);
  assign sts.hit      = addr_eq && (rd_entry.protocol == req_q.protocol)
                        && (rd_entry.port == req_q.src_port);
  assign sts.scan_end = (ptr >= count) && !cmp_v;

  always_comb begin
    rsp_next             = '0;
    rsp_next.any_learned = learned;
    if (cmd.fin_known) begin
      rsp_next.status = flt_pkg::STATUS_KNOWN;
    end else if (cmd.fin_learn) begin
      if (full) begin
        rsp_next.status = flt_pkg::STATUS_FULL;
      end else begin
        rsp_next.status       = flt_pkg::STATUS_ADDED;
        rsp_next.instance_res = inst_new;
        rsp_next.any_learned  = 1'b1;
      end
    end else begin
      rsp_next.status = flt_pkg::STATUS_READ;
      if (idx_ok) begin
        rsp_next.instance_res     = rd_entry.inst;
        rsp_next.entry_valid      = 1'b1;
        rsp_next.entry_address    = rd_entry.address;
        rsp_next.entry_protocol   = rd_entry.protocol;
        rsp_next.entry_port       = rd_entry.port;
        rsp_next.first_of_address = (rd_entry.inst == flt_pkg::INST_ONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      cmp_v   <= 1'b0;
      count   <= '0;
      learned <= 1'b0;
      done    <= 1'b0;
    end else begin
      cmp_v <= rd_en;
      done  <= fin;
      if (cmd.load) begin
        ptr <= '0;
      end else if (rd_en) begin
        ptr <= ptr + CW'(1);
      end
      if (we) begin
        count   <= count + CW'(1);
        learned <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
      same  <= '0;
    end else if (addr_eq && cmd.scan) begin
      same <= inst_new;
    end
    if (fin) begin
      result <= rsp_next;
    end
  end

  `FLT_ASSERT(a_count_max, count <= CW'(TABLE_ENTRIES), "entry count beyond table size")
  `FLT_ASSERT(a_done_src, done |-> $past(fin), "result strobe without a finish")
  `FLT_ASSERT(a_add_flag, we |=> learned && done, "add not reflected in flag and strobe")

endmodule

// ----- tb/flow_learning_table_unit_test.sv -----
// ----------------------------------------------------------------------------
// flow_learning_table_unit_test
// Self-checking testbench of the flow learning table. Learn and read requests
// go in through the start/busy handshake. Each result is checked field by
// field against a predictor that keeps its own copy of the table. Directed
// corner cases come first. The table is then filled with random traffic and
// driven to full, with random sender gaps except in the closing stretch.
// ----------------------------------------------------------------------------
module flow_learning_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = flt_pkg::TABLE_ENTRIES_DEF;
  localparam int INST_W        = flt_pkg::INST_W;
  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam logic [31:0] HOT_ADDR = 32'hC0A8_0001;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  flt_pkg::req_t  req;
  logic           done;
  flt_pkg::rsp_t  result;

  logic [31:0]       flow_addr  [TABLE_ENTRIES];
  logic [7:0]        flow_proto [TABLE_ENTRIES];
  logic [15:0]       flow_port  [TABLE_ENTRIES];
  logic [INST_W-1:0] flow_inst  [TABLE_ENTRIES];
  int                flow_count;
  logic              flow_learned;

  flt_pkg::rsp_t expected_rsp_q[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int requests_sent;
  int n_added;
  int n_known;
  int n_dropped;
  int n_reads;

  flow_learning_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .result(result)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rsp_q.size());
      $display("flow_learning_table_unit_test failed");
      $finish;
    end
  end

  function automatic flt_pkg::rsp_t predict_flow(input flt_pkg::req_t r);
    flt_pkg::rsp_t p;
    int   i;
    int   same;
    logic found;
    p = '0;
    if (r.opcode == flt_pkg::OP_LEARN) begin
      same  = 0;
      found = 1'b0;
      for (i = 0; i < flow_count && !found; i++) begin
        if (flow_addr[i] == r.src_ip) begin
          same++;
          if (flow_port[i] == r.src_port && flow_proto[i] == r.protocol) found = 1'b1;
        end
      end
      if (found) begin
        p.status = flt_pkg::STATUS_KNOWN;
      end else if (flow_count >= TABLE_ENTRIES) begin
        p.status = flt_pkg::STATUS_FULL;
      end else begin
        flow_addr[flow_count]  = r.src_ip;
        flow_proto[flow_count] = r.protocol;
        flow_port[flow_count]  = r.src_port;
        flow_inst[flow_count]  = INST_W'(same + 1);
        p.status       = flt_pkg::STATUS_ADDED;
        p.instance_res = flow_inst[flow_count];
        flow_count++;
        flow_learned = 1'b1;
      end
    end else begin
      p.status = flt_pkg::STATUS_READ;
      if (r.entry_index < flow_count) begin
        p.instance_res     = flow_inst[r.entry_index];
        p.entry_valid      = 1'b1;
        p.entry_address    = flow_addr[r.entry_index];
        p.entry_protocol   = flow_proto[r.entry_index];
        p.entry_port       = flow_port[r.entry_index];
        p.first_of_address = (flow_inst[r.entry_index] == flt_pkg::INST_ONE);
      end
    end
    p.any_learned = flow_learned;
    return p;
  endfunction

  function automatic flt_pkg::req_t random_flow_req();
    flt_pkg::req_t r;
    int   k;
    r.opcode      = ($urandom_range(99, 0) < 65) ? flt_pkg::OP_LEARN : flt_pkg::OP_READ;
    r.src_ip      = $urandom();
    r.protocol    = 8'($urandom());
    r.src_port    = 16'($urandom());
    r.entry_index = 8'($urandom());
    if (r.opcode == flt_pkg::OP_LEARN) begin
      k = $urandom_range(9, 0);
      if (k < 4 && flow_count > 0) begin
        k          = $urandom_range(flow_count - 1, 0);
        r.src_ip   = flow_addr[k];
        r.protocol = flow_proto[k];
        r.src_port = flow_port[k];
      end else if (k < 9) begin
        case ($urandom_range(5, 0))
          0:       r.src_ip = 32'h0000_0000;
          1:       r.src_ip = 32'hFFFF_FFFF;
          2:       r.src_ip = 32'h0A00_0001;
          3:       r.src_ip = HOT_ADDR;
          default: r.src_ip = {24'h0A0000, 8'($urandom_range(3, 0))};
        endcase
        case ($urandom_range(4, 0))
          0:       r.protocol = 8'd0;
          1:       r.protocol = 8'd6;
          2:       r.protocol = 8'd17;
          3:       r.protocol = 8'hFF;
          default: r.protocol = 8'($urandom());
        endcase
        if (r.protocol == 8'd0 && $urandom_range(1, 0) == 0) r.src_port = 16'd0;
        else if ($urandom_range(7, 0) == 0) r.src_port = 16'hFFFF;
        else r.src_port = 16'($urandom_range(7, 0));
      end
    end else if (flow_count > 0 && $urandom_range(1, 0) == 0) begin
      r.entry_index = 8'($urandom_range(flow_count - 1, 0));
    end
    return r;
  endfunction

  // Hold the request until accepted, then predict and queue its result.
  task automatic send_request(input flt_pkg::req_t item);
    flt_pkg::rsp_t predicted;
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    predicted = predict_flow(item);
    expected_rsp_q.push_back(predicted);
    requests_sent++;
    case (predicted.status)
      flt_pkg::STATUS_KNOWN: n_known++;
      flt_pkg::STATUS_ADDED: n_added++;
      flt_pkg::STATUS_FULL:  n_dropped++;
      default:               n_reads++;
    endcase
  endtask

  task automatic sender_gap();
    if ($urandom_range(3, 0) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic op, input logic [31:0] ip, input logic [7:0] proto,
                             input logic [15:0] port, input logic [7:0] idx);
    flt_pkg::req_t r;
    r.opcode      = op;
    r.src_ip      = ip;
    r.protocol    = proto;
    r.src_port    = port;
    r.entry_index = idx;
    send_request(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    flt_pkg::rsp_t exp_rsp;
    if (!rst && done) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, result);
        mismatch_count++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        check_field("status", 32'(exp_rsp.status), 32'(result.status));
        check_field("instance_res", 32'(exp_rsp.instance_res), 32'(result.instance_res));
        check_field("entry_valid", 32'(exp_rsp.entry_valid), 32'(result.entry_valid));
        check_field("entry_address", exp_rsp.entry_address, result.entry_address);
        check_field("entry_protocol", 32'(exp_rsp.entry_protocol),
                    32'(result.entry_protocol));
        check_field("entry_port", 32'(exp_rsp.entry_port), 32'(result.entry_port));
        check_field("first_of_address", 32'(exp_rsp.first_of_address),
                    32'(result.first_of_address));
        check_field("any_learned", 32'(exp_rsp.any_learned), 32'(result.any_learned));
      end
    end
  end

  task automatic test_empty_table();
    send_fields(flt_pkg::OP_READ, 32'h0, 8'h0, 16'h0, 8'd0);
    send_fields(flt_pkg::OP_READ, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_fields(flt_pkg::OP_LEARN, 32'h0, 8'd0, 16'd0, 8'h0);
    sender_gap();
    send_fields(flt_pkg::OP_LEARN, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_fields(flt_pkg::OP_LEARN, 32'h0, 8'd0, 16'd0, 8'h55);
    send_fields(flt_pkg::OP_LEARN, 32'h0, 8'd6, 16'd80, 8'h0);
    send_fields(flt_pkg::OP_LEARN, 32'h0, 8'd0, 16'd1, 8'h0);
    send_fields(flt_pkg::OP_LEARN, 32'h0, 8'd6, 16'd0, 8'h0);
    send_fields(flt_pkg::OP_LEARN, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'h0);
    sender_gap();
    for (int i = 0; i < 6; i++) begin
      send_fields(flt_pkg::OP_READ, ~32'(i), 8'hFF, 16'hFFFF, 8'(i));
    end
    send_fields(flt_pkg::OP_READ, 32'h0, 8'h0, 16'h0, 8'hFF);
    send_fields(flt_pkg::OP_READ, 32'h0, 8'h0, 16'h0, 8'h80);
  endtask

  task automatic test_random_traffic(input int count, input logic with_gaps);
    for (int i = 0; i < count; i++) begin
      send_request(random_flow_req());
      if (with_gaps) sender_gap();
    end
  endtask

  task automatic test_fill_table();
    int k;
    k = 0;
    while (flow_count < TABLE_ENTRIES) begin
      send_fields(flt_pkg::OP_LEARN, HOT_ADDR, 8'd132, 16'(1000 + k), 8'($urandom()));
      sender_gap();
      k++;
    end
  endtask

  task automatic test_full_table();
    send_fields(flt_pkg::OP_LEARN, 32'h0BAD_F00D, 8'd6, 16'd443, 8'h0);
    send_fields(flt_pkg::OP_LEARN, HOT_ADDR, 8'd133, 16'd7, 8'h0);
    send_fields(flt_pkg::OP_LEARN, flow_addr[0], flow_proto[0], flow_port[0], 8'h0);
    sender_gap();
    send_fields(flt_pkg::OP_LEARN, flow_addr[TABLE_ENTRIES-1], flow_proto[TABLE_ENTRIES-1],
                flow_port[TABLE_ENTRIES-1], 8'hFF);
    send_fields(flt_pkg::OP_READ, 32'h0, 8'h0, 16'h0, 8'd0);
    send_fields(flt_pkg::OP_READ, 32'h0, 8'h0, 16'h0, 8'(TABLE_ENTRIES - 1));
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    req            = '0;
    requests_sent  = 0;
    n_added        = 0;
    n_known        = 0;
    n_dropped      = 0;
    n_reads        = 0;
    flow_count     = 0;
    flow_learned   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_random_traffic(400, 1'b1);
    test_fill_table();
    test_full_table();
    test_random_traffic(450, 1'b1);
    test_random_traffic(300, 1'b0);

    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    $display("Covered %0d requests: %0d flows added, %0d known, %0d dropped on a full table,",
             requests_sent, n_added, n_known, n_dropped);
    $display("and %0d reads, with the table filled to %0d entries.", n_reads, flow_count);
    if (mismatch_count == 0) begin
      $display("flow_learning_table_unit_test passed");
    end else begin
      $display("flow_learning_table_unit_test failed");
    end
    $finish;
  end

endmodule
